FILE: hdl/assert_macros.svh
// Assertion helpers shared by the RTL.
// Both macros check one implication on the rising edge of the given clock,
// with the check held off while reset is high.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// Consequent must hold in the same cycle as the antecedent.
`define ASSERT_NOW(lbl, clock, reset, ante, cons) \
  lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// Consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, clock, reset, ante, cons) \
  lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`else

`define ASSERT_NOW(lbl, clock, reset, ante, cons)
`define ASSERT_NEXT(lbl, clock, reset, ante, cons)

`endif

`endif

FILE: hdl/prao_pkg.sv
package prao_pkg;

  // CORDIC x/y datapath width (Q2.30 values, magnitude stays near 2^30)
  localparam int CW = 32;

  // Angle scale factors to 2^-34 turn units
  localparam logic [31:0] RAD_TO_TURN  = 32'd2734261102;
  localparam logic [31:0] DEG_TO_TURN  = 32'd47721859;

  // CORDIC start vector length, gain compensated, Q2.30
  localparam logic signed [CW-1:0] GAIN_Q30 = 32'sd652032874;

  // One eighth of a turn in 2^-32 turn units
  localparam logic [31:0] EIGHTH_TURN = 32'h2000_0000;

  // Quadrant codes taken from the top two phase bits
  typedef logic [1:0] quad_t;
  localparam quad_t QUAD_EAST  = 2'd0;
  localparam quad_t QUAD_NORTH = 2'd1;
  localparam quad_t QUAD_WEST  = 2'd2;
  localparam quad_t QUAD_SOUTH = 2'd3;

  // Geometry that rides along the CORDIC chain
  typedef struct packed {
    quad_t              quad;
    logic signed [32:0] dx;
    logic signed [32:0] dy;
    logic signed [31:0] cx;
    logic signed [31:0] cy;
  } prao_geom_t;

  // One beat between CORDIC cells
  typedef struct packed {
    logic                 valid;
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [31:0]   z;
    prao_geom_t           geom;
  } prao_beat_t;

  // arctan(2^-i) in 2^-32 turn units
  function automatic logic [31:0] atan_turn(input int idx);
    case (idx)
      0:  return 32'd536870912;
      1:  return 32'd316933406;
      2:  return 32'd167458907;
      3:  return 32'd85004756;
      4:  return 32'd42667331;
      5:  return 32'd21354465;
      6:  return 32'd10679838;
      7:  return 32'd5340245;
      8:  return 32'd2670163;
      9:  return 32'd1335087;
      10: return 32'd667544;
      11: return 32'd333772;
      12: return 32'd166886;
      13: return 32'd83443;
      14: return 32'd41722;
      15: return 32'd20861;
      16: return 32'd10430;
      17: return 32'd5215;
      18: return 32'd2608;
      19: return 32'd1304;
      20: return 32'd652;
      21: return 32'd326;
      22: return 32'd163;
      23: return 32'd81;
      24: return 32'd41;
      25: return 32'd20;
      26: return 32'd10;
      27: return 32'd5;
      28: return 32'd3;
      29: return 32'd1;
      30: return 32'd1;
      default: return 32'd0;
    endcase
  endfunction

endpackage

FILE: hdl/prao_front.sv
module prao_front import prao_pkg::*; #(
  parameter int FRACTION_BITS = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [31:0] point_x,
  input  logic signed [31:0] point_y,
  input  logic signed [31:0] center_x,
  input  logic signed [31:0] center_y,
  input  logic signed [31:0] turn_angle,
  input  logic               angle_is_degrees,
  output prao_beat_t         dn,
  input  logic               dn_ready
);

  localparam int F = FRACTION_BITS;

  logic [31:0]        scale;
  logic signed [64:0] prod;
  logic [31:0]        phase_next;
  logic signed [32:0] dx_next, dy_next;

  logic               valid;
  logic [31:0]        phase;
  logic signed [32:0] dx, dy;
  logic signed [31:0] cx, cy;
  logic [31:0]        phase_off;
  logic [31:0]        resid;

  // angle to phase: one signed multiply, keep 32 bits of turn
  always_comb begin
    scale      = angle_is_degrees ? DEG_TO_TURN : RAD_TO_TURN;
    prod       = 65'(turn_angle) * 65'($signed({1'b0, scale}));
    phase_next = prod[F+33:F+2];
    dx_next    = 33'(point_x) - 33'(center_x);
    dy_next    = 33'(point_y) - 33'(center_y);
  end

  assign in_ready = !valid || dn_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ready) begin
      valid <= in_valid;
      phase <= phase_next;
      dx    <= dx_next;
      dy    <= dy_next;
      cx    <= center_x;
      cy    <= center_y;
    end
  end

  // quadrant split; residual in [-1/8, 1/8) turn
  always_comb begin
    phase_off    = phase + EIGHTH_TURN;
    resid        = {2'b00, phase_off[29:0]} - EIGHTH_TURN;
    dn.valid     = valid;
    dn.x         = GAIN_Q30;
    dn.y         = '0;
    dn.z         = $signed(resid);
    dn.geom.quad = phase_off[31:30];
    dn.geom.dx   = dx;
    dn.geom.dy   = dy;
    dn.geom.cx   = cx;
    dn.geom.cy   = cy;
  end

endmodule

FILE: hdl/prao_cell.sv
module prao_cell import prao_pkg::*; #(
  parameter int INDEX = 0
) (
  input  logic       clk,
  input  logic       rst,
  input  prao_beat_t up,
  output logic       up_ready,
  output prao_beat_t dn,
  input  logic       dn_ready
);

  localparam logic signed [31:0] ATAN = atan_turn(INDEX);

  logic signed [CW-1:0] xs, ys;
  prao_beat_t           dn_next;

  // one micro-rotation, direction from the sign of the residual angle
  always_comb begin
    xs      = up.x >>> INDEX;
    ys      = up.y >>> INDEX;
    dn_next = up;
    if (!up.z[31]) begin
      dn_next.x = up.x - ys;
      dn_next.y = up.y + xs;
      dn_next.z = up.z - ATAN;
    end else begin
      dn_next.x = up.x + ys;
      dn_next.y = up.y - xs;
      dn_next.z = up.z + ATAN;
    end
  end

  // stage takes a beat when empty or when its successor takes ours
  assign up_ready = !dn.valid || dn_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      dn.valid <= 1'b0;
    end else if (up_ready) begin
      dn <= dn_next;
    end
  end

endmodule

FILE: hdl/prao_finish.sv
`include "assert_macros.svh"

module prao_finish import prao_pkg::*; #(
  parameter int FRACTION_BITS = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  prao_beat_t         up,
  output logic               up_ready,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] rotated_x,
  output logic signed [31:0] rotated_y,
  output logic               saturated
);

  localparam int F   = FRACTION_BITS;
  localparam int PW  = 65;         // coordinate x trig product
  localparam int TW  = 67;         // exact rotated sum, Q.(F+30)
  localparam int VW  = TW - 14;    // after dropping 14 bits
  localparam int MW  = VW;         // magnitude
  localparam int SW  = MW + 7;     // magnitude * 100 plus bias
  localparam int HW  = SW - (F + 16);
  localparam int QW  = 34;
  localparam int FTW = F;

  // hundredth counts at or above this always clip
  localparam logic [63:0] H_LIM =
    (64'd100 * 64'd2147483648 + 64'd50 + (64'd1 << F) - 64'd1) >> F;
  localparam int DW  = $clog2(H_LIM);
  // reciprocal of 25, exact for DW-bit operands
  localparam int RS  = DW + 5;
  localparam int RW  = DW + 1;
  localparam logic [63:0] RECIP = ((64'd1 << RS) + 64'd24) / 64'd25;
  localparam int PRW = DW + RW;
  localparam int QHW = DW - 4;

  localparam logic [SW-1:0] HUND_BIAS = SW'(64'd1 << (F + 15));
  localparam logic [QW-1:0] POS_LIM   = QW'(64'h7FFF_FFFF);
  localparam logic [QW-1:0] NEG_LIM   = QW'(64'h8000_0000);

  // pipeline stages
  localparam int ST_M = 0;
  localparam int ST_T = 1;
  localparam int ST_H = 2;
  localparam int ST_D = 3;
  localparam int ST_Q = 4;
  localparam int NS   = 5;

  logic [NS-1:0] stage_valid;
  logic [NS:0]   stage_ready;

  // fraction of a hundredth block: round(r * 2^F / 100), r < 25
  logic [FTW-1:0] frac_tbl [32];
  for (genvar g = 0; g < 32; g++) begin : g_frac
    localparam int FRAC = (g * (1 << F) + 50) / 100;
    assign frac_tbl[g] = FTW'(FRAC);
  end

  // ready ripples back: a stage moves when empty or when drained
  always_comb begin
    stage_ready[NS] = !out_valid || out_ready;
    for (int k = NS - 1; k >= 0; k--) begin
      stage_ready[k] = !stage_valid[k] || stage_ready[k + 1];
    end
  end
  assign up_ready = stage_ready[ST_M];

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= '0;
      out_valid   <= 1'b0;
    end else begin
      if (stage_ready[ST_M]) stage_valid[ST_M] <= up.valid;
      for (int k = 1; k < NS; k++) begin
        if (stage_ready[k]) stage_valid[k] <= stage_valid[k - 1];
      end
      if (stage_ready[NS]) out_valid <= stage_valid[ST_Q];
    end
  end

  // ---- stage M: quadrant fold and four products
  logic signed [CW-1:0] cosv, sinv;
  logic signed [PW-1:0] prod_next [4];
  logic signed [PW-1:0] prod_q    [4];
  logic signed [31:0]   ctr_q     [2];

  always_comb begin
    unique case (up.geom.quad)
      QUAD_EAST:  begin cosv = up.x;  sinv = up.y;  end
      QUAD_NORTH: begin cosv = -up.y; sinv = up.x;  end
      QUAD_WEST:  begin cosv = -up.x; sinv = -up.y; end
      default:    begin cosv = up.y;  sinv = -up.x; end
    endcase
    prod_next[0] = PW'(up.geom.dx) * PW'(cosv);
    prod_next[1] = PW'(up.geom.dy) * PW'(sinv);
    prod_next[2] = PW'(up.geom.dx) * PW'(sinv);
    prod_next[3] = PW'(up.geom.dy) * PW'(cosv);
  end

  always_ff @(posedge clk) begin
    if (stage_ready[ST_M]) begin
      prod_q   <= prod_next;
      ctr_q[0] <= up.geom.cx;
      ctr_q[1] <= up.geom.cy;
    end
  end

  // ---- stage T: exact sums with the center added back
  logic signed [TW-1:0] t_next [2];
  logic signed [TW-1:0] t_q    [2];

  always_comb begin
    t_next[0] = TW'(prod_q[0]) - TW'(prod_q[1]) + (TW'(ctr_q[0]) <<< 30);
    t_next[1] = TW'(prod_q[2]) + TW'(prod_q[3]) + (TW'(ctr_q[1]) <<< 30);
  end

  always_ff @(posedge clk) begin
    if (stage_ready[ST_T]) t_q <= t_next;
  end

  // ---- stage H: sign/magnitude and count of hundredths
  logic signed [VW-1:0] v     [2];
  logic [MW-1:0]        mag   [2];
  logic [SW-1:0]        hsum  [2];
  logic [HW-1:0]        h_next[2];
  logic [1:0]           neg_next;
  logic [HW-1:0]        h_q   [2];
  logic [1:0]           neg_h;

  always_comb begin
    for (int l = 0; l < 2; l++) begin
      v[l]        = VW'(t_q[l] >>> 14);
      neg_next[l] = v[l][VW-1];
      mag[l]      = neg_next[l] ? MW'(-v[l]) : MW'(v[l]);
      // times 100 as 64 + 32 + 4, then half a unit for rounding
      hsum[l]     = (SW'(mag[l]) << 6) + (SW'(mag[l]) << 5) + (SW'(mag[l]) << 2)
                  + HUND_BIAS;
      h_next[l]   = hsum[l][SW-1:F+16];
    end
  end

  always_ff @(posedge clk) begin
    if (stage_ready[ST_H]) begin
      h_q   <= h_next;
      neg_h <= neg_next;
    end
  end

  // ---- stage D: range check and quotient by 25
  logic [PRW-1:0] rp      [2];
  logic [DW-1:0]  hl_next [2];
  logic [QHW-1:0] hq_next [2];
  logic [1:0]     big_next;
  logic [DW-1:0]  hl_d    [2];
  logic [QHW-1:0] hq_d    [2];
  logic [1:0]     big_d;
  logic [1:0]     neg_d;

  always_comb begin
    for (int l = 0; l < 2; l++) begin
      big_next[l] = (64'(h_q[l]) >= H_LIM);
      hl_next[l]  = h_q[l][DW-1:0];
      rp[l]       = PRW'(hl_next[l]) * PRW'(RECIP[RW-1:0]);
      hq_next[l]  = rp[l][RS+QHW-1:RS];
    end
  end

  always_ff @(posedge clk) begin
    if (stage_ready[ST_D]) begin
      hl_d  <= hl_next;
      hq_d  <= hq_next;
      big_d <= big_next;
      neg_d <= neg_h;
    end
  end

  // ---- stage Q: back to Q.F, quotient part plus table for the remainder
  logic [DW-1:0]  rem    [2];
  logic [QW-1:0]  q_next [2];
  logic [QW-1:0]  q_q    [2];
  logic [1:0]     big_q;
  logic [1:0]     neg_q;

  always_comb begin
    for (int l = 0; l < 2; l++) begin
      rem[l]    = hl_d[l] - DW'(hq_d[l]) * DW'(5'd25);
      q_next[l] = (QW'(hq_d[l]) << (F - 2)) + QW'(frac_tbl[rem[l][4:0]]);
    end
  end

  always_ff @(posedge clk) begin
    if (stage_ready[ST_Q]) begin
      q_q   <= q_next;
      big_q <= big_d;
      neg_q <= neg_d;
    end
  end

  // ---- output register: sign, clip, flag
  logic [1:0]        clip;
  logic [QW-1:0]     qn  [2];
  logic [31:0]       res [2];

  always_comb begin
    for (int l = 0; l < 2; l++) begin
      qn[l]   = -q_q[l];
      clip[l] = big_q[l] || (neg_q[l] ? (q_q[l] > NEG_LIM) : (q_q[l] > POS_LIM));
      if (clip[l]) begin
        res[l] = neg_q[l] ? 32'h8000_0000 : 32'h7FFF_FFFF;
      end else begin
        res[l] = neg_q[l] ? qn[l][31:0] : q_q[l][31:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (stage_ready[NS]) begin
      rotated_x <= $signed(res[0]);
      rotated_y <= $signed(res[1]);
      saturated <= |clip;
    end
  end

  // reciprocal divide must leave a remainder below 25
  `ASSERT_NOW(a_rem_range, clk, rst, stage_valid[ST_D], (big_d[0] || rem[0] < DW'(25)) && (big_d[1] || rem[1] < DW'(25)))
  // a clipped beat carries at least one rail value
  `ASSERT_NOW(a_sat_rail, clk, rst, out_valid && saturated, rotated_x == 32'sh7FFF_FFFF || rotated_x == 32'sh8000_0000 || rotated_y == 32'sh7FFF_FFFF || rotated_y == 32'sh8000_0000)

endmodule

FILE: hdl/point_rotate_about_origin.sv
// Channel  Dir  Handshake            Payload
// in       in   in_valid/in_ready    point_x point_y center_x center_y turn_angle
//                                    angle_is_degrees
// out      out  out_valid/out_ready  rotated_x rotated_y saturated
//
// One beat per clock when the output is not held. Registers in order: angle
// multiply, one per CORDIC cell, five product and rounding stages, output.
// Each CORDIC cell, like every other stage, takes a beat a cycle when not held.
// Reset clears only the valid bits of every stage.
// Each stage holds while its successor is full, so bubbles close up and a
// held result at the output does not stop the stages behind it until they fill.
`include "assert_macros.svh"

module point_rotate_about_origin import prao_pkg::*; #(
  parameter int CORDIC_STAGES = 20,
  parameter int FRACTION_BITS = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [31:0] point_x,
  input  logic signed [31:0] point_y,
  input  logic signed [31:0] center_x,
  input  logic signed [31:0] center_y,
  input  logic signed [31:0] turn_angle,
  input  logic               angle_is_degrees,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] rotated_x,
  output logic signed [31:0] rotated_y,
  output logic               saturated
);

  prao_beat_t beat  [CORDIC_STAGES+1];
  logic       ready [CORDIC_STAGES+1];

  // angle to phase, center subtraction
  prao_front #(
    .FRACTION_BITS(FRACTION_BITS)
  ) u_front (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .point_x         (point_x),
    .point_y         (point_y),
    .center_x        (center_x),
    .center_y        (center_y),
    .turn_angle      (turn_angle),
    .angle_is_degrees(angle_is_degrees),
    .dn              (beat[0]),
    .dn_ready        (ready[0])
  );

  // CORDIC chain, one cell per iteration
  for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_cell
    prao_cell #(
      .INDEX(g)
    ) u_cell (
      .clk     (clk),
      .rst     (rst),
      .up      (beat[g]),
      .up_ready(ready[g]),
      .dn      (beat[g+1]),
      .dn_ready(ready[g+1])
    );
  end

  // rotation products, rounding to hundredths, saturation
  prao_finish #(
    .FRACTION_BITS(FRACTION_BITS)
  ) u_finish (
    .clk      (clk),
    .rst      (rst),
    .up       (beat[CORDIC_STAGES]),
    .up_ready (ready[CORDIC_STAGES]),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .rotated_x(rotated_x),
    .rotated_y(rotated_y),
    .saturated(saturated)
  );

  // input can only back up when every stage is full and the output is held
  `ASSERT_NOW(a_backpressure, clk, rst, !in_ready, out_valid && !out_ready)

endmodule
